>>> hdl/mmc3_pkg.sv
// Shared types, codes and constants of the MMC3 bank mapper.
`timescale 1ns / 1ps
package mmc3_pkg;

	localparam int PRG_MASK_W = 6;
	localparam int CHR_MASK_W = 8;
	localparam int ADDR_W     = 16;
	localparam int DATA_W     = 8;
	localparam int MAP_W      = 19;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int NUM_BANKS  = 8;

	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_CLOCK = 2'd1,
		FUNC_CPU   = 2'd2,
		FUNC_PPU   = 2'd3
	} func_t;

	localparam logic [CFG_IDX_W-1:0] CFG_PRG_MASK    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHR_MASK    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FOUR_SCREEN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RAM_PROT_IGN = 2'd3;

	localparam logic [ADDR_W-1:0] REG_DECODE_MASK = 16'hE001;
	localparam logic [ADDR_W-1:0] REG_BANK_SELECT = 16'h8000;
	localparam logic [ADDR_W-1:0] REG_BANK_DATA   = 16'h8001;
	localparam logic [ADDR_W-1:0] REG_MIRROR      = 16'hA000;
	localparam logic [ADDR_W-1:0] REG_RAM_PROTECT = 16'hA001;
	localparam logic [ADDR_W-1:0] REG_CNT_LATCH   = 16'hC000;
	localparam logic [ADDR_W-1:0] REG_CNT_RELOAD  = 16'hC001;
	localparam logic [ADDR_W-1:0] REG_IRQ_DISABLE = 16'hE000;
	localparam logic [ADDR_W-1:0] REG_IRQ_ENABLE  = 16'hE001;

	localparam logic [1:0] PROT_READ_WRITE = 2'b10;
	localparam logic [1:0] PROT_READ_ONLY  = 2'b11;

	localparam logic [PRG_MASK_W-1:0] PRG_MASK_RESET   = 6'h3F;
	localparam logic [CHR_MASK_W-1:0] CHR_MASK_RESET   = 8'hFF;
	localparam logic [PRG_MASK_W-1:0] PRG_SECOND_LAST  = 6'h3E;

	typedef struct packed {
		logic                  prg_mode;
		logic                  chr_invert;
		logic [NUM_BANKS-1:0][DATA_W-1:0] bank_regs;
		logic [PRG_MASK_W-1:0] prg_mask;
		logic [CHR_MASK_W-1:0] chr_mask;
	} bank_state_t;

	typedef struct packed {
		logic mirror_horizontal;
		logic prg_ram_read_enable;
		logic prg_ram_write_enable;
		logic irq_pending;
	} status_t;

endpackage

>>> hdl/mmc3_if.sv
// Handshake channel interfaces for items, results and configuration writes.
`timescale 1ns / 1ps
interface mmc3_req_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                func;
	logic [mmc3_pkg::ADDR_W-1:0] bus_address;
	logic [mmc3_pkg::DATA_W-1:0] write_data;

	modport source (output valid, func, bus_address, write_data, input ready);
	modport sink (input valid, func, bus_address, write_data, output ready);
endinterface

interface mmc3_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [mmc3_pkg::MAP_W-1:0] mapped_address;
	logic                       address_hit;
	logic                       mirror_horizontal;
	logic                       prg_ram_read_enable;
	logic                       prg_ram_write_enable;
	logic                       irq_pending;

	modport source (output valid, mapped_address, address_hit, mirror_horizontal,
		prg_ram_read_enable, prg_ram_write_enable, irq_pending, input ready);
	modport sink (input valid, mapped_address, address_hit, mirror_horizontal,
		prg_ram_read_enable, prg_ram_write_enable, irq_pending, output ready);
endinterface

interface mmc3_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mmc3_pkg::CFG_IDX_W-1:0]  index;
	logic [mmc3_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/mmc3_bank_mapper_irq.sv
// Top level of the MMC3 bank mapper with scanline IRQ counter.
// A result beat is offered from the result register once its item has passed the input register.
// Throughput: one item per cycle; the input stalls only while the result register is full
// and not taken, through the input register and result register pair.
// Reset: all mapper state clears to zero, masks to full size, both registers empty.
`timescale 1ns / 1ps
module mmc3_bank_mapper_irq (
	input logic      clk,
	input logic      arst_n,
	mmc3_req_if.sink   req,
	mmc3_rsp_if.source rsp,
	mmc3_cfg_if.sink   cfg
);
	import mmc3_pkg::*;

	logic              valid_s1;
	logic [1:0]        func_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic [DATA_W-1:0] data_s1;
	logic              advance;

	logic              valid_s2;
	logic [MAP_W-1:0]  mapped_s2;
	logic              hit_s2;
	status_t           status_s2;

	bank_state_t       bank_state;
	status_t           status_next;
	logic [MAP_W-1:0]  mapped;
	logic              hit;

	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_s1 <= req.func;
			addr_s1 <= req.bus_address;
			data_s1 <= req.write_data;
		end
	end

	mmc3_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (advance),
		.func        (func_s1),
		.bus_address (addr_s1),
		.write_data  (data_s1),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.bank_state  (bank_state),
		.status_next (status_next)
	);

	mmc3_xlate u_xlate (
		.func           (func_s1),
		.bus_address    (addr_s1),
		.bank_state     (bank_state),
		.mapped_address (mapped),
		.address_hit    (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mapped_s2 <= mapped;
			hit_s2    <= hit;
			status_s2 <= status_next;
		end
	end

	assign rsp.valid                = valid_s2;
	assign rsp.mapped_address       = mapped_s2;
	assign rsp.address_hit          = hit_s2;
	assign rsp.mirror_horizontal    = status_s2.mirror_horizontal;
	assign rsp.prg_ram_read_enable  = status_s2.prg_ram_read_enable;
	assign rsp.prg_ram_write_enable = status_s2.prg_ram_write_enable;
	assign rsp.irq_pending          = status_s2.irq_pending;
endmodule

>>> hdl/mmc3_regs.sv
// Mapper register file: configuration, CPU write decode and the scanline IRQ counter.
`timescale 1ns / 1ps
module mmc3_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            fire,
	input  logic [1:0]                      func,
	input  logic [mmc3_pkg::ADDR_W-1:0]     bus_address,
	input  logic [mmc3_pkg::DATA_W-1:0]     write_data,
	input  logic                            cfg_we,
	input  logic [mmc3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mmc3_pkg::CFG_DATA_W-1:0] cfg_data,
	output mmc3_pkg::bank_state_t           bank_state,
	output mmc3_pkg::status_t               status_next
);
	import mmc3_pkg::*;

	logic [PRG_MASK_W-1:0] prg_mask_q;
	logic [CHR_MASK_W-1:0] chr_mask_q;
	logic                  four_screen_q;
	logic                  ram_prot_ign_q;

	logic [2:0]            bank_select_q, bank_select_d;
	logic                  prg_mode_q, prg_mode_d;
	logic                  chr_invert_q, chr_invert_d;
	logic [NUM_BANKS-1:0][DATA_W-1:0] bank_regs_q, bank_regs_d;
	logic                  mirror_q, mirror_d;
	logic                  ram_rd_q, ram_rd_d;
	logic                  ram_wr_q, ram_wr_d;
	logic [DATA_W-1:0]     latch_q, latch_d;
	logic [DATA_W-1:0]     count_q, count_d;
	logic                  reload_q, reload_d;
	logic                  irq_en_q, irq_en_d;
	logic                  irq_flag_q, irq_flag_d;
	logic [ADDR_W-1:0]     reg_addr;

	assign reg_addr = bus_address & REG_DECODE_MASK;

	always_comb begin
		bank_select_d = bank_select_q;
		prg_mode_d    = prg_mode_q;
		chr_invert_d  = chr_invert_q;
		bank_regs_d   = bank_regs_q;
		mirror_d      = mirror_q;
		ram_rd_d      = ram_rd_q;
		ram_wr_d      = ram_wr_q;
		latch_d       = latch_q;
		count_d       = count_q;
		reload_d      = reload_q;
		irq_en_d      = irq_en_q;
		irq_flag_d    = irq_flag_q;
		if (func == FUNC_WRITE) begin
			unique case (reg_addr)
				REG_BANK_SELECT: begin
					bank_select_d = write_data[2:0];
					prg_mode_d    = write_data[6];
					chr_invert_d  = write_data[7];
				end
				REG_BANK_DATA: bank_regs_d[bank_select_q] = write_data;
				REG_MIRROR: begin
					if (!four_screen_q) begin
						mirror_d = write_data[0];
					end
				end
				REG_RAM_PROTECT: begin
					if (!ram_prot_ign_q) begin
						case (write_data[7:6])
							PROT_READ_WRITE: begin
								ram_rd_d = 1'b1;
								ram_wr_d = 1'b1;
							end
							PROT_READ_ONLY: begin
								ram_rd_d = 1'b1;
								ram_wr_d = 1'b0;
							end
							default: begin
								ram_rd_d = 1'b0;
								ram_wr_d = 1'b0;
							end
						endcase
					end
				end
				REG_CNT_LATCH: latch_d = write_data;
				REG_CNT_RELOAD: begin
					reload_d = 1'b1;
					count_d  = '0;
				end
				REG_IRQ_DISABLE: begin
					irq_en_d   = 1'b0;
					irq_flag_d = 1'b0;
				end
				REG_IRQ_ENABLE: irq_en_d = 1'b1;
				default: begin
				end
			endcase
		end else if (func == FUNC_CLOCK) begin
			if (count_q == '0 || reload_q) begin
				count_d  = latch_q;
				reload_d = 1'b0;
			end else begin
				count_d = count_q - 1'b1;
			end
			if (count_d == '0 && irq_en_q) begin
				irq_flag_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_select_q <= '0;
			prg_mode_q    <= 1'b0;
			chr_invert_q  <= 1'b0;
			bank_regs_q   <= '0;
			mirror_q      <= 1'b0;
			ram_rd_q      <= 1'b0;
			ram_wr_q      <= 1'b0;
			latch_q       <= '0;
			count_q       <= '0;
			reload_q      <= 1'b0;
			irq_en_q      <= 1'b0;
			irq_flag_q    <= 1'b0;
		end else if (fire) begin
			bank_select_q <= bank_select_d;
			prg_mode_q    <= prg_mode_d;
			chr_invert_q  <= chr_invert_d;
			bank_regs_q   <= bank_regs_d;
			mirror_q      <= mirror_d;
			ram_rd_q      <= ram_rd_d;
			ram_wr_q      <= ram_wr_d;
			latch_q       <= latch_d;
			count_q       <= count_d;
			reload_q      <= reload_d;
			irq_en_q      <= irq_en_d;
			irq_flag_q    <= irq_flag_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_mask_q     <= PRG_MASK_RESET;
			chr_mask_q     <= CHR_MASK_RESET;
			four_screen_q  <= 1'b0;
			ram_prot_ign_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PRG_MASK:     prg_mask_q     <= cfg_data[PRG_MASK_W-1:0];
				CFG_CHR_MASK:     chr_mask_q     <= cfg_data[CHR_MASK_W-1:0];
				CFG_FOUR_SCREEN:  four_screen_q  <= cfg_data[0];
				CFG_RAM_PROT_IGN: ram_prot_ign_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	assign bank_state.prg_mode   = prg_mode_q;
	assign bank_state.chr_invert = chr_invert_q;
	assign bank_state.bank_regs  = bank_regs_q;
	assign bank_state.prg_mask   = prg_mask_q;
	assign bank_state.chr_mask   = chr_mask_q;

	assign status_next.mirror_horizontal    = mirror_d;
	assign status_next.prg_ram_read_enable  = ram_rd_d;
	assign status_next.prg_ram_write_enable = ram_wr_d;
	assign status_next.irq_pending          = irq_flag_d;

`ifndef ASSERT_OFF
	a_irq_disable_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && func == FUNC_WRITE && reg_addr == REG_IRQ_DISABLE |=> !irq_flag_q)
		else $error("IRQ pending survived a disable write");
	a_irq_rise_on_clock: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(irq_flag_q) |-> $past(fire && func == FUNC_CLOCK && irq_en_q))
		else $error("IRQ pending rose without an enabled A12 clock");
	a_reload_write: assert property (@(posedge clk) disable iff (!arst_n)
		fire && func == FUNC_WRITE && reg_addr == REG_CNT_RELOAD
		|=> reload_q && count_q == '0)
		else $error("reload write did not clear the counter and set reload");
`endif
endmodule

>>> hdl/mmc3_xlate.sv
// PRG and CHR address translation through the current bank registers.
`timescale 1ns / 1ps
module mmc3_xlate (
	input  logic [1:0]                  func,
	input  logic [mmc3_pkg::ADDR_W-1:0] bus_address,
	input  mmc3_pkg::bank_state_t       bank_state,
	output logic [mmc3_pkg::MAP_W-1:0]  mapped_address,
	output logic                        address_hit
);
	import mmc3_pkg::*;

	logic [1:0]            prg_slot;
	logic [PRG_MASK_W-1:0] prg_bank;
	logic [PRG_MASK_W-1:0] second_last;
	logic [PRG_MASK_W-1:0] r6, r7;
	logic [2:0]            chr_slot;
	logic [2:0]            chr_idx;
	logic [DATA_W-1:0]     chr_raw;
	logic [CHR_MASK_W-1:0] chr_bank;

	assign second_last = PRG_SECOND_LAST & bank_state.prg_mask;
	assign r6 = bank_state.bank_regs[6][PRG_MASK_W-1:0] & bank_state.prg_mask;
	assign r7 = bank_state.bank_regs[7][PRG_MASK_W-1:0] & bank_state.prg_mask;
	assign prg_slot = bus_address[14:13];

	always_comb begin
		case (prg_slot)
			2'd0:    prg_bank = bank_state.prg_mode ? second_last : r6;
			2'd1:    prg_bank = r7;
			2'd2:    prg_bank = bank_state.prg_mode ? r6 : second_last;
			default: prg_bank = bank_state.prg_mask;
		endcase
	end

	assign chr_slot = bus_address[12:10] ^ {bank_state.chr_invert, 2'b00};
	assign chr_idx  = chr_slot - 3'd2;

	always_comb begin
		if (chr_slot[2:1] == 2'b00) begin
			chr_raw = {bank_state.bank_regs[0][DATA_W-1:1], chr_slot[0]};
		end else if (chr_slot[2:1] == 2'b01) begin
			chr_raw = {bank_state.bank_regs[1][DATA_W-1:1], chr_slot[0]};
		end else begin
			chr_raw = bank_state.bank_regs[chr_idx];
		end
	end

	assign chr_bank = chr_raw & bank_state.chr_mask;

	always_comb begin
		mapped_address = '0;
		address_hit    = 1'b0;
		if (func == FUNC_CPU && bus_address[15]) begin
			mapped_address = {prg_bank, bus_address[12:0]};
			address_hit    = 1'b1;
		end else if (func == FUNC_PPU && !bus_address[13]) begin
			mapped_address = {1'b0, chr_bank, bus_address[9:0]};
			address_hit    = 1'b1;
		end
	end
endmodule

>>> tb/sv/mmc3_bank_mapper_irq_tb.sv
// Self-checking testbench for the MMC3 bank mapper with its scanline IRQ counter.
`timescale 1ns / 1ps
module mmc3_bank_mapper_irq_tb;
	import mmc3_pkg::*;

	localparam int STALL_PCT   = 29;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE      = 4;

	localparam logic [ADDR_W-1:0] REG_BASES [8] = '{REG_BANK_SELECT, REG_BANK_DATA,
		REG_MIRROR, REG_RAM_PROTECT, REG_CNT_LATCH, REG_CNT_RELOAD, REG_IRQ_DISABLE,
		REG_IRQ_ENABLE};

	typedef struct packed {
		logic [MAP_W-1:0] mapped_address;
		logic             address_hit;
		status_t          status;
	} map_result_t;

	class mapper_tracker;
		bit [PRG_MASK_W-1:0] prg_mask = PRG_MASK_RESET;
		bit [CHR_MASK_W-1:0] chr_mask = CHR_MASK_RESET;
		bit                  four_screen;
		bit                  ram_prot_ign;
		bit [2:0]            bank_sel;
		bit                  prg_mode;
		bit                  chr_invert;
		bit [DATA_W-1:0]     bank_regs [NUM_BANKS];
		bit                  mirror;
		bit                  ram_rd;
		bit                  ram_wr;
		bit [7:0]            cnt_latch;
		bit [7:0]            irq_count;
		bit                  cnt_reload;
		bit                  irq_en;
		bit                  irq_flag;
		map_result_t         pending_maps [$];
		int                  errors;

		function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_PRG_MASK: prg_mask = val[PRG_MASK_W-1:0];
				CFG_CHR_MASK: chr_mask = val;
				CFG_FOUR_SCREEN: four_screen = val[0];
				CFG_RAM_PROT_IGN: ram_prot_ign = val[0];
				default: ;
			endcase
		endfunction

		function void note_item(func_t f, bit [ADDR_W-1:0] a, bit [DATA_W-1:0] d);
			map_result_t         r;
			bit [2:0]            s;
			bit [PRG_MASK_W-1:0] second_last;
			bit [PRG_MASK_W-1:0] r6;
			bit [PRG_MASK_W-1:0] r7;
			bit [PRG_MASK_W-1:0] pbank;
			bit [7:0]            cbank;
			r = '0;
			case (f)
				FUNC_WRITE: begin
					case (a & REG_DECODE_MASK)
						REG_BANK_SELECT: begin
							bank_sel = d[2:0];
							prg_mode = d[6];
							chr_invert = d[7];
						end
						REG_BANK_DATA: bank_regs[bank_sel] = d;
						REG_MIRROR: if (!four_screen) mirror = d[0];
						REG_RAM_PROTECT: if (!ram_prot_ign) begin
							ram_rd = d[7];
							ram_wr = (d[7:6] == PROT_READ_WRITE);
						end
						REG_CNT_LATCH: cnt_latch = d;
						REG_CNT_RELOAD: begin
							cnt_reload = 1'b1;
							irq_count = '0;
						end
						REG_IRQ_DISABLE: begin
							irq_en = 1'b0;
							irq_flag = 1'b0;
						end
						REG_IRQ_ENABLE: irq_en = 1'b1;
						default: ;
					endcase
				end
				FUNC_CLOCK: begin
					if (irq_count == 0 || cnt_reload) begin
						irq_count = cnt_latch;
						cnt_reload = 1'b0;
					end else begin
						irq_count = irq_count - 8'd1;
					end
					if (irq_count == 0 && irq_en)
						irq_flag = 1'b1;
				end
				FUNC_CPU: if (a[15]) begin
					second_last = PRG_SECOND_LAST & prg_mask;
					r6 = bank_regs[6][PRG_MASK_W-1:0] & prg_mask;
					r7 = bank_regs[7][PRG_MASK_W-1:0] & prg_mask;
					case (a[14:13])
						2'd0: pbank = prg_mode ? second_last : r6;
						2'd1: pbank = r7;
						2'd2: pbank = prg_mode ? r6 : second_last;
						default: pbank = prg_mask;
					endcase
					r.mapped_address = {pbank, a[12:0]};
					r.address_hit = 1'b1;
				end
				default: if (!a[13]) begin
					s = a[12:10] ^ {chr_invert, 2'b00};
					if (s < 3'd2)
						cbank = {bank_regs[0][7:1], s[0]};
					else if (s < 3'd4)
						cbank = {bank_regs[1][7:1], s[0]};
					else
						cbank = bank_regs[s - 3'd2];
					r.mapped_address = {1'b0, cbank & chr_mask, a[9:0]};
					r.address_hit = 1'b1;
				end
			endcase
			r.status.mirror_horizontal = mirror;
			r.status.prg_ram_read_enable = ram_rd;
			r.status.prg_ram_write_enable = ram_wr;
			r.status.irq_pending = irq_flag;
			pending_maps.push_back(r);
		endfunction

		function void report(string what, longint unsigned want, longint unsigned seen);
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, seen);
			errors++;
		endfunction

		function void check_result(map_result_t got);
			map_result_t want;
			if (pending_maps.size() == 0) begin
				$display("%0t: result beat mismatch, expected no beat, actual mapped_address 0x%0h",
					$time, got.mapped_address);
				errors++;
			end else begin
				want = pending_maps.pop_front();
				if (got.mapped_address !== want.mapped_address)
					report("mapped_address", want.mapped_address, got.mapped_address);
				if (got.address_hit !== want.address_hit)
					report("address_hit", want.address_hit, got.address_hit);
				if (got.status.mirror_horizontal !== want.status.mirror_horizontal)
					report("mirror_horizontal", want.status.mirror_horizontal,
						got.status.mirror_horizontal);
				if (got.status.prg_ram_read_enable !== want.status.prg_ram_read_enable)
					report("prg_ram_read_enable", want.status.prg_ram_read_enable,
						got.status.prg_ram_read_enable);
				if (got.status.prg_ram_write_enable !== want.status.prg_ram_write_enable)
					report("prg_ram_write_enable", want.status.prg_ram_write_enable,
						got.status.prg_ram_write_enable);
				if (got.status.irq_pending !== want.status.irq_pending)
					report("irq_pending", want.status.irq_pending, got.status.irq_pending);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   steady;
	int   items_sent;
	int   quiet_cycles;

	mapper_tracker tracker;
	map_result_t   seen;

	mmc3_req_if req_ch ();
	mmc3_rsp_if rsp_ch ();
	mmc3_cfg_if cfg_ch ();

	mmc3_bank_mapper_irq u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(negedge clk) begin
		rsp_ch.ready <= steady || ($urandom_range(99) >= STALL_PCT);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				tracker.set_reg(cfg_ch.index, cfg_ch.data);
			if (rsp_ch.valid && rsp_ch.ready) begin
				seen.mapped_address = rsp_ch.mapped_address;
				seen.address_hit = rsp_ch.address_hit;
				seen.status.mirror_horizontal = rsp_ch.mirror_horizontal;
				seen.status.prg_ram_read_enable = rsp_ch.prg_ram_read_enable;
				seen.status.prg_ram_write_enable = rsp_ch.prg_ram_write_enable;
				seen.status.irq_pending = rsp_ch.irq_pending;
				tracker.check_result(seen);
			end
			if (req_ch.valid && req_ch.ready)
				tracker.note_item(func_t'(req_ch.func), req_ch.bus_address, req_ch.write_data);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	function automatic logic [ADDR_W-1:0] reg_addr(logic [ADDR_W-1:0] base);
		return base | (ADDR_W'($urandom) & 16'h1FFE);
	endfunction

	task automatic send_item(func_t f, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
		if (!steady) begin
			while ($urandom_range(99) < STALL_PCT) begin
				req_ch.valid <= 1'b0;
				@(negedge clk);
			end
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.bus_address <= a;
		req_ch.write_data <= d;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
		if (!(f == FUNC_WRITE && !a[15]))
			items_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		@(negedge clk);
	endtask

	task automatic set_phase(int prg, int chr, bit fs, bit prot_ign);
		write_reg(CFG_PRG_MASK, CFG_DATA_W'(prg));
		write_reg(CFG_CHR_MASK, CFG_DATA_W'(chr));
		write_reg(CFG_FOUR_SCREEN, CFG_DATA_W'(fs));
		write_reg(CFG_RAM_PROT_IGN, CFG_DATA_W'(prot_ign));
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (tracker.pending_maps.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic run_random(int n);
		int              start_count;
		int              pick;
		int              k;
		logic [ADDR_W-1:0] a;
		logic [7:0]      latch;
		start_count = items_sent;
		while (items_sent - start_count < n) begin
			pick = $urandom_range(99);
			if (pick < 22) begin
				a = ADDR_W'($urandom);
				if ($urandom_range(99) < 80)
					a[15] = 1'b1;
				send_item(FUNC_CPU, a, DATA_W'($urandom));
			end else if (pick < 44) begin
				a = ADDR_W'($urandom);
				if ($urandom_range(99) < 75)
					a[13] = 1'b0;
				send_item(FUNC_PPU, a, DATA_W'($urandom));
			end else if (pick < 56) begin
				send_item(FUNC_WRITE, reg_addr(REG_BANK_SELECT), DATA_W'($urandom));
				send_item(FUNC_WRITE, reg_addr(REG_BANK_DATA), DATA_W'($urandom));
			end else if (pick < 64) begin
				send_item(FUNC_WRITE, reg_addr(REG_BASES[$urandom_range(7)]),
					DATA_W'($urandom));
			end else if (pick < 80) begin
				latch = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(6));
				send_item(FUNC_WRITE, reg_addr(REG_CNT_LATCH), latch);
				send_item(FUNC_WRITE, reg_addr(REG_CNT_RELOAD), DATA_W'($urandom));
				send_item(FUNC_WRITE, reg_addr(($urandom_range(3) == 0) ?
					REG_IRQ_DISABLE : REG_IRQ_ENABLE), DATA_W'($urandom));
				k = $urandom_range(1, 10);
				repeat (k) send_item(FUNC_CLOCK, ADDR_W'($urandom), DATA_W'($urandom));
			end else if (pick < 88) begin
				send_item(FUNC_CLOCK, ADDR_W'($urandom), DATA_W'($urandom));
			end else begin
				send_item(func_t'($urandom_range(3)), ADDR_W'($urandom), DATA_W'($urandom));
			end
		end
	endtask

	initial begin
		tracker = new();
		arst_n = 1'b0;
		steady = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_WRITE;
		req_ch.bus_address = '0;
		req_ch.write_data = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_PRG_MASK;
		cfg_ch.data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		set_phase(PRG_MASK_RESET, CHR_MASK_RESET, 1'b0, 1'b0);
		send_item(FUNC_CPU, 16'h0000, 8'h00);
		send_item(FUNC_CPU, 16'h7FFF, 8'hFF);
		send_item(FUNC_PPU, 16'h0000, 8'h00);
		send_item(FUNC_PPU, 16'hFFFF, 8'h00);
		send_item(FUNC_PPU, 16'h2000, 8'h00);
		send_item(FUNC_WRITE, REG_BANK_SELECT, 8'hC6);
		send_item(FUNC_WRITE, REG_BANK_DATA | 16'h1FFE, 8'hFF);
		send_item(FUNC_WRITE, 16'h7FFF, 8'hFF);
		send_item(FUNC_CPU, 16'h8000, 8'h00);
		send_item(FUNC_CPU, 16'hC000, 8'h00);
		send_item(FUNC_CPU, 16'hFFFF, 8'h00);
		send_item(FUNC_PPU, 16'h1FFF, 8'h00);
		send_item(FUNC_PPU, 16'hC3FF, 8'h00);
		send_item(FUNC_WRITE, REG_MIRROR, 8'hFF);
		send_item(FUNC_WRITE, REG_RAM_PROTECT, 8'h80);
		send_item(FUNC_WRITE, REG_RAM_PROTECT, 8'hC0);
		send_item(FUNC_WRITE, REG_RAM_PROTECT, 8'h40);
		send_item(FUNC_WRITE, REG_CNT_LATCH, 8'h00);
		send_item(FUNC_WRITE, REG_CNT_RELOAD, 8'h00);
		send_item(FUNC_WRITE, REG_IRQ_ENABLE, 8'h00);
		send_item(FUNC_CLOCK, 16'h0000, 8'h00);
		send_item(FUNC_CLOCK, 16'hFFFF, 8'hFF);
		send_item(FUNC_WRITE, REG_IRQ_DISABLE, 8'h00);
		send_item(FUNC_WRITE, REG_CNT_LATCH, 8'hFF);
		send_item(FUNC_WRITE, REG_CNT_RELOAD, 8'h00);
		send_item(FUNC_CLOCK, 16'h0000, 8'h00);
		send_item(FUNC_CLOCK, 16'h0000, 8'h00);
		run_random(400);
		drain();

		set_phase(1, 7, 1'b1, 1'b1);
		run_random(350);
		drain();

		set_phase((1 << $urandom_range(1, 6)) - 1, (1 << $urandom_range(3, 8)) - 1,
			1'($urandom), 1'($urandom));
		run_random(150);
		steady = 1'b1;
		run_random(200);
		steady = 1'b0;
		drain();

		set_phase(PRG_MASK_RESET, CHR_MASK_RESET, 1'b1, 1'b0);
		run_random(175);
		drain();
		run_random(175);
		drain();

		set_phase((1 << $urandom_range(1, 6)) - 1, (1 << $urandom_range(3, 8)) - 1,
			1'($urandom), 1'($urandom));
		run_random(400);
		drain();

		if (tracker.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> files.f
hdl/mmc3_pkg.sv
hdl/mmc3_if.sv
hdl/mmc3_regs.sv
hdl/mmc3_xlate.sv
hdl/mmc3_bank_mapper_irq.sv
tb/sv/mmc3_bank_mapper_irq_tb.sv
